>>> hw/rtl/mas_pkg.sv
package mas_pkg;

  typedef enum logic [2:0] {
    NUC_N = 3'd0,
    NUC_A = 3'd1,
    NUC_C = 3'd2,
    NUC_G = 3'd3,
    NUC_T = 3'd4
  } nuc_e;

  // register indexes of the configuration port
  localparam logic [2:0] CfgStart = 3'd5;
  localparam logic [2:0] CfgEnd   = 3'd6;
  localparam int unsigned CfgCount = 7;

  localparam logic [11:0] PosMax = 12'hfff;
  localparam logic [31:0] TotalMax = 32'hffff_ffff;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_WRITE,
    ST_QRESP
  } state_e;

  typedef struct packed {
    logic       kind;
    logic [6:0] base_char;
    logic       read_end;
    logic [4:0] query_adapter;
    logic [7:0] query_position;
  } req_t;

  typedef struct packed {
    logic [31:0] hit_count;
    logic [31:0] reads_counted;
    logic [11:0] longest_read;
    logic        overflow;
  } rsp_t;

  function automatic nuc_e nuc_class(input logic [6:0] ch);
    nuc_e cls;
    case (ch)
      7'h41, 7'h61: cls = NUC_A;
      7'h43, 7'h63: cls = NUC_C;
      7'h47, 7'h67: cls = NUC_G;
      7'h54, 7'h74: cls = NUC_T;
      default:      cls = NUC_N;
    endcase
    return cls;
  endfunction

endpackage

>>> hw/rtl/mas_stream_if.sv
interface mas_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/mas_ram.sv
module mas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> hw/rtl/multi_adapter_shift_and_counter_top.sv
// a character goes to CALC; each counted adapter hit then passes CALC, READ and WRITE (one counter
//   read-modify-write through the single counter memory each), a hit past the store CALC and READ
// a query reads its counter in IDLE and loads its response register in QRESP, waiting there while the output stalls
// requests are taken one at a time, only in IDLE, once the previous item is through
// reset: async active low; after reset a clearing pass over all MAX_ADAPTERS*MAX_READ_LEN
//   counters (8192 by default) zeroes them before the first request is taken
module multi_adapter_shift_and_counter_top #(
  parameter int WORD_BITS    = 64,
  parameter int MAX_ADAPTERS = 32,
  parameter int MAX_READ_LEN = 256,
  parameter int COUNT_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  mas_stream_if.sink   req_i,
  mas_stream_if.source rsp_o
);
  localparam int Depth = MAX_ADAPTERS * MAX_READ_LEN;
  localparam int AddrW = $clog2(Depth);
  localparam int IdxW  = $clog2(WORD_BITS);

  logic [63:0] cfg_q [mas_pkg::CfgCount];

  mas_pkg::state_e state_q, state_d;

  logic [WORD_BITS-1:0] mv_q, mv_d, found_q, found_d, pend_q, pend_d;
  logic [WORD_BITS-1:0] hit1h_q, hit1h_d;
  logic [IdxW-1:0]      ord_q, ord_d, len_q, len_d;
  logic                 end_q, end_d;
  logic [11:0]          cp_q, cp_d, maxlen_q, maxlen_d;
  logic [31:0]          total_q, total_d;
  logic                 ovf_q, ovf_d;
  logic                 qoor_q, qoor_d;
  logic [AddrW-1:0]     addr_q, addr_d, clr_q, clr_d;
  logic                 rsp_valid_q, rsp_valid_d;
  mas_pkg::rsp_t        rsp_q, rsp_d;

  logic                  ram_we, ram_re;
  logic [AddrW-1:0]      ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  logic [WORD_BITS-1:0] starts, ends, sel, mv_next, lowm, pick;
  logic [IdxW-1:0]      e_idx, s_idx;
  logic [12:0]          cp1, pos;
  logic                 hit_bad;
  logic [AddrW-1:0]     hit_addr, q_addr;
  logic [63:0]          cnt_ext;
  logic                 accept;
  mas_pkg::nuc_e        cls;

  assign starts  = cfg_q[mas_pkg::CfgStart][WORD_BITS-1:0];
  assign ends    = cfg_q[mas_pkg::CfgEnd][WORD_BITS-1:0];
  assign cls     = mas_pkg::nuc_class(req_i.data.base_char);
  assign sel     = cfg_q[cls][WORD_BITS-1:0];
  assign mv_next = ((mv_q & sel) << 1) | starts;
  assign accept  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == mas_pkg::ST_IDLE);

  // lowest pending end bit, its bit index and the nearest start below it
  assign pick = pend_q & (~pend_q + 1'b1);
  assign lowm = pick - 1'b1;
  always_comb begin
    e_idx = '0;
    s_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (pick[i]) e_idx = IdxW'(i);
      if (starts[i] && lowm[i]) s_idx = IdxW'(i);
    end
  end

  assign cp1      = {1'b0, cp_q} + 13'd1;
  assign pos      = cp1 - 13'(len_q);
  assign hit_bad  = (32'(ord_q) >= 32'(MAX_ADAPTERS)) || (cp1 < 13'(len_q)) ||
                    (32'(pos) >= 32'(MAX_READ_LEN));
  assign hit_addr = AddrW'(32'(ord_q) * 32'(MAX_READ_LEN) + 32'(pos));
  assign q_addr   = AddrW'(32'(req_i.data.query_adapter) * 32'(MAX_READ_LEN) +
                           32'(req_i.data.query_position));
  assign cnt_ext  = 64'(ram_rdata);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mas_pkg::ST_CLEAR: if (32'(clr_q) == Depth - 1) state_d = mas_pkg::ST_IDLE;
      mas_pkg::ST_IDLE: begin
        if (accept) state_d = req_i.data.kind ? mas_pkg::ST_QRESP : mas_pkg::ST_CALC;
      end
      mas_pkg::ST_CALC:  state_d = (pend_q == '0) ? mas_pkg::ST_IDLE : mas_pkg::ST_READ;
      mas_pkg::ST_READ:  state_d = hit_bad ? mas_pkg::ST_CALC : mas_pkg::ST_WRITE;
      mas_pkg::ST_WRITE: state_d = mas_pkg::ST_CALC;
      mas_pkg::ST_QRESP: if (!rsp_valid_q || rsp_o.ready) state_d = mas_pkg::ST_IDLE;
      default:           state_d = mas_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    mv_d = mv_q; found_d = found_q; pend_d = pend_q; hit1h_d = hit1h_q;
    ord_d = ord_q; len_d = len_q; end_d = end_q; cp_d = cp_q;
    maxlen_d = maxlen_q; total_d = total_q; ovf_d = ovf_q; qoor_d = qoor_q;
    addr_d = addr_q; clr_d = clr_q; rsp_d = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    ram_we = 1'b0; ram_waddr = addr_q; ram_wdata = '0;
    ram_re = 1'b0; ram_raddr = hit_addr;
    case (state_q)
      mas_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
      end
      mas_pkg::ST_IDLE: begin
        if (accept && req_i.data.kind) begin
          ram_re    = 1'b1;
          ram_raddr = q_addr;
          qoor_d    = (32'(req_i.data.query_adapter) >= 32'(MAX_ADAPTERS)) ||
                      (32'(req_i.data.query_position) >= 32'(MAX_READ_LEN));
        end else if (accept) begin
          mv_d   = mv_next;
          pend_d = mv_next & ends & ~found_q;
          end_d  = req_i.data.read_end;
        end
      end
      mas_pkg::ST_CALC: begin
        if (pend_q == '0) begin
          if (end_q) begin
            if (total_q != mas_pkg::TotalMax) total_d = total_q + 32'd1;
            if (cp1[12]) maxlen_d = mas_pkg::PosMax;
            else if (cp1[11:0] > maxlen_q) maxlen_d = cp1[11:0];
            mv_d    = starts;
            found_d = '0;
            cp_d    = '0;
          end else if (cp_q != mas_pkg::PosMax) begin
            cp_d = cp_q + 12'd1;
          end
        end else begin
          hit1h_d = lowm + 1'b1;
          ord_d   = IdxW'($countones(ends & lowm));
          len_d   = e_idx - s_idx;
          found_d = found_q | (lowm + 1'b1);
          pend_d  = pend_q & ~(lowm + 1'b1);
        end
      end
      mas_pkg::ST_READ: begin
        if (hit_bad) begin
          ovf_d = 1'b1;
        end else begin
          ram_re = 1'b1;
          addr_d = hit_addr;
        end
      end
      mas_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;
      end
      mas_pkg::ST_QRESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d         = 1'b1;
          rsp_d.hit_count     = qoor_q ? 32'd0 : cnt_ext[31:0];
          rsp_d.reads_counted = total_q;
          rsp_d.longest_read  = maxlen_q;
          rsp_d.overflow      = ovf_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mas_pkg::CfgCount; i++) cfg_q[i] <= '0;
      state_q     <= mas_pkg::ST_CLEAR;
      mv_q        <= '0;
      found_q     <= '0;
      pend_q      <= '0;
      end_q       <= 1'b0;
      cp_q        <= '0;
      maxlen_q    <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (32'(cfg_idx_i) < mas_pkg::CfgCount)) cfg_q[cfg_idx_i] <= cfg_wdata_i;
      state_q     <= state_d;
      mv_q        <= mv_d;
      found_q     <= found_d;
      pend_q      <= pend_d;
      end_q       <= end_d;
      cp_q        <= cp_d;
      maxlen_q    <= maxlen_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit1h_q <= hit1h_d;
    ord_q   <= ord_d;
    len_q   <= len_d;
    qoor_q  <= qoor_d;
    addr_q  <= addr_d;
    rsp_q   <= rsp_d;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  mas_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (Depth)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(ovf_q))
    else $error("overflow flag cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == mas_pkg::ST_QRESP))
    else $error("response without a query");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mas_pkg::ST_WRITE) |-> ((hit1h_q & found_q) == hit1h_q))
    else $error("counted hit not marked as found");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q & found_q) == '0)
    else $error("pending hit already found");
`endif
endmodule
